>>> rtl/tlfs_pkg.sv
// Shared types and constants for the tank level fill supervisor.
package tlfs_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int TIME_BITS = 16;
    localparam int CNT_BITS = 8;

    localparam logic [SAMPLE_BITS-1:0] THR_LOW_RST  = SAMPLE_BITS'(80);
    localparam logic [SAMPLE_BITS-1:0] THR_WORK_RST = SAMPLE_BITS'(180);
    localparam logic [SAMPLE_BITS-1:0] THR_HIGH_RST = SAMPLE_BITS'(240);
    localparam logic [SAMPLE_BITS-1:0] THR_NONE_RST = SAMPLE_BITS'(500);
    localparam logic [CNT_BITS-1:0]    DRY_LIMIT_RST = CNT_BITS'(10);
    localparam logic [TIME_BITS-1:0]   FILL_OPEN_RST  = TIME_BITS'(10);
    localparam logic [TIME_BITS-1:0]   FILL_CLOSE_RST = TIME_BITS'(10);

    localparam logic [TIME_BITS-1:0] SHUT_OPEN_TIME  = TIME_BITS'(0);
    localparam logic [TIME_BITS-1:0] SHUT_CLOSE_TIME = TIME_BITS'(10);
    localparam logic [CNT_BITS-1:0]  CNT_MAX = {CNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        CL_UNKNOWN = 3'd0,
        CL_LOW     = 3'd1,
        CL_WORK    = 3'd2,
        CL_UPPER   = 3'd3,
        CL_NONE    = 3'd4
    } t_class;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_FILLING   = 3'd1,
        PH_NORMAL    = 3'd2,
        PH_ALARM     = 3'd3,
        PH_CONFIRMED = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        VC_KEEP = 2'd0,
        VC_FILL = 2'd1,
        VC_SHUT = 2'd2
    } t_valve;

    typedef enum logic [1:0] {
        AL_NONE     = 2'd0,
        AL_DRY      = 2'd1,
        AL_OVERFLOW = 2'd2
    } t_alarm;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THR_LOW    = 3'd0,
        CFG_THR_WORK   = 3'd1,
        CFG_THR_HIGH   = 3'd2,
        CFG_THR_NONE   = 3'd3,
        CFG_DRY_LIMIT  = 3'd4,
        CFG_FILL_OPEN  = 3'd5,
        CFG_FILL_CLOSE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] confirm_sample;
        logic                   emergency;
    } t_in_item;

    typedef struct packed {
        t_class                level_class;
        t_phase                phase;
        t_valve                valve_cmd;
        logic [TIME_BITS-1:0]  valve_open_time;
        logic [TIME_BITS-1:0]  valve_close_time;
        t_alarm                alarm;
        logic [CNT_BITS-1:0]   alarm_count;
    } t_out_item;

endpackage

>>> rtl/tank_level_fill_supervisor_top.sv
// Tank level fill supervisor: classification, phase machine, valve command and alarms.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  input    | i_in_valid   | o_in_stall   | i_in  (sample, confirm, emerg)
//  result   | o_out_valid  | i_out_stall  | o_out (class, phase, valve, alarm)
//  config   | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while i_out_stall is low; a beat passes from the input register
// to the result register once the result register is empty or being taken.
// The whole tick update is one combinational pass from the input register and state.
// Synchronous active-low reset clears state and loads the threshold defaults.
// A stalled result holds the input register; input stalls only when both are full.
module tank_level_fill_supervisor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tlfs_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tlfs_pkg::t_out_item             o_out,
    input  logic                            i_cfg_we,
    input  logic [tlfs_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [tlfs_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import tlfs_pkg::*;

    logic [SAMPLE_BITS-1:0] r_thr_low, r_thr_work, r_thr_high, r_thr_none;
    logic [CNT_BITS-1:0]    r_dry_limit;
    logic [TIME_BITS-1:0]   r_fill_open, r_fill_close;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    t_phase              r_phase, n_phase;
    t_class              r_class, n_class;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    t_phase              w_eff_phase;
    t_class              w_c1, w_c2;
    t_valve              w_cmd;
    t_alarm              w_alarm;
    logic [CNT_BITS-1:0] w_cnt_inc;
    logic                w_adv;
    t_out_item           w_res;

    // last threshold that holds wins; below all keeps the previous class
    function automatic t_class f_classify(
        input logic [SAMPLE_BITS-1:0] s,
        input t_class                 prev,
        input logic [SAMPLE_BITS-1:0] t_low,
        input logic [SAMPLE_BITS-1:0] t_work,
        input logic [SAMPLE_BITS-1:0] t_high,
        input logic [SAMPLE_BITS-1:0] t_none
    );
        t_class c;
        c = prev;
        if (s >= t_low)  c = CL_LOW;
        if (s >= t_work) c = CL_WORK;
        if (s >= t_high) c = CL_UPPER;
        if (s >= t_none) c = CL_NONE;
        return c;
    endfunction

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low    <= THR_LOW_RST;
            r_thr_work   <= THR_WORK_RST;
            r_thr_high   <= THR_HIGH_RST;
            r_thr_none   <= THR_NONE_RST;
            r_dry_limit  <= DRY_LIMIT_RST;
            r_fill_open  <= FILL_OPEN_RST;
            r_fill_close <= FILL_CLOSE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THR_LOW:    r_thr_low    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_THR_WORK:   r_thr_work   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_THR_HIGH:   r_thr_high   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_THR_NONE:   r_thr_none   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_DRY_LIMIT:  r_dry_limit  <= i_cfg_data[CNT_BITS-1:0];
                CFG_FILL_OPEN:  r_fill_open  <= i_cfg_data[TIME_BITS-1:0];
                CFG_FILL_CLOSE: r_fill_close <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // emergency forces normal before the phase dispatch
    assign w_eff_phase = r_in.emergency ? PH_NORMAL : r_phase;
    assign w_c1 = f_classify(r_in.sample, r_class,
                             r_thr_low, r_thr_work, r_thr_high, r_thr_none);
    assign w_c2 = f_classify(r_in.confirm_sample, w_c1,
                             r_thr_low, r_thr_work, r_thr_high, r_thr_none);
    assign w_cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_BITS'(1);

    always_comb begin
        n_phase = w_eff_phase;
        n_class = w_c1;
        n_cnt   = r_cnt;
        w_cmd   = VC_KEEP;
        w_alarm = AL_NONE;
        case (w_eff_phase)
            PH_IDLE: begin
                n_phase = (w_c1 == CL_LOW) ? PH_FILLING : PH_NORMAL;
            end
            PH_FILLING: begin
                w_cmd = VC_FILL;
                if (w_c1 == CL_WORK || w_c1 == CL_UPPER) begin
                    n_class = w_c2;
                    if (w_c2 == CL_WORK || w_c2 == CL_UPPER) n_phase = PH_CONFIRMED;
                end
            end
            PH_NORMAL: begin
                if (w_c1 == CL_LOW || w_c1 == CL_UPPER) begin
                    n_class = w_c2;
                    n_cnt   = CNT_BITS'(1);
                    if (w_c2 == CL_LOW || w_c2 == CL_UPPER) n_phase = PH_ALARM;
                end
                // re-read may have moved the class to working or none
                if (n_class == CL_WORK) begin
                    w_cmd = VC_FILL;
                    n_cnt = '0;
                end
                if (n_class == CL_NONE) begin
                    w_cmd = VC_SHUT;
                    n_cnt = '0;
                end
            end
            PH_ALARM: begin
                if (w_c1 == CL_LOW) begin
                    n_cnt   = w_cnt_inc;
                    n_class = w_c2;
                    if (w_cnt_inc > r_dry_limit) w_alarm = AL_DRY;
                end else if (w_c1 == CL_UPPER) begin
                    n_cnt   = w_cnt_inc;
                    n_class = w_c2;
                    w_alarm = AL_OVERFLOW;
                end else begin
                    n_phase = PH_NORMAL;
                    n_cnt   = '0;
                end
            end
            PH_CONFIRMED: begin
                if (w_c1 == CL_WORK || w_c1 == CL_UPPER) n_phase = PH_NORMAL;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_res.level_class = n_class;
        w_res.phase       = n_phase;
        w_res.valve_cmd   = w_cmd;
        w_res.alarm       = w_alarm;
        w_res.alarm_count = n_cnt;
        case (w_cmd)
            VC_FILL: begin
                w_res.valve_open_time  = r_fill_open;
                w_res.valve_close_time = r_fill_close;
            end
            VC_SHUT: begin
                w_res.valve_open_time  = SHUT_OPEN_TIME;
                w_res.valve_close_time = SHUT_CLOSE_TIME;
            end
            default: begin
                w_res.valve_open_time  = '0;
                w_res.valve_close_time = '0;
            end
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_class     <= CL_UNKNOWN;
            r_cnt       <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_class     <= n_class;
                r_cnt       <= n_cnt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in <= i_in;
        if (w_adv) r_out <= w_res;
    end

`ifndef SYNTHESIS
    a_alarm_in_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.alarm != AL_NONE |-> o_out.phase == PH_ALARM)
        else $error("alarm raised outside alarm pending phase");

    a_shut_on_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.valve_cmd == VC_SHUT
            |-> o_out.level_class == CL_NONE && o_out.alarm_count == '0)
        else $error("shut-off without none class or with live counter");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid)
        else $error("input beat dropped while stalled");

    a_state_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !w_adv |=> $stable(r_cnt) && $stable(r_phase) && $stable(r_class))
        else $error("state changed without an item");
`endif

endmodule
